>>> rtl/ctcgd_pkg.sv
// Shared types and constants of the CTC greedy decoder.
`default_nettype none
package ctcgd_pkg;

  localparam int unsigned SCORE_W = 16;
  localparam int unsigned CLASS_W = 13;
  localparam int unsigned COUNT_W = 9;
  localparam int unsigned TOTAL_W = 25;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CLASS_W-1:0] BLANK_RESET = 13'd8191;
  localparam logic signed [SCORE_W-1:0] THRESH_RESET = 16'sd16384;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 9'd511;

  localparam logic [CFG_IDX_W-1:0] CFG_BLANK_CLASS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DROP_THRESHOLD = 1'd1;

  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic step_end;
    logic sequence_end;
  } in_item_t;

  typedef struct packed {
    logic kind;
    logic [CLASS_W-1:0] char_class;
    logic signed [SCORE_W-1:0] char_score;
    logic signed [SCORE_W-1:0] mean_score;
    logic [COUNT_W-1:0] kept_count;
    logic final_res;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic div_start;
    logic load_sum;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic seq_close;
    logic div_done;
  } dp_status_t;

endpackage
`default_nettype wire

>>> rtl/ctcgd_if.sv
// Valid/ready channel interfaces for the score input and the result output.
`default_nettype none
interface ctcgd_in_if;
  logic valid;
  logic ready;
  ctcgd_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ctcgd_out_if;
  logic valid;
  logic ready;
  ctcgd_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/ctcgd_div.sv
// Bit-serial signed-by-unsigned divider for the mean kept score.
`default_nettype none
module ctcgd_div (
  input  wire logic                                      clk,
  input  wire logic                                      rst_n,
  input  wire logic                                      start,
  input  wire logic                                      ack,
  input  wire logic signed [ctcgd_pkg::TOTAL_W-1:0]      dividend,
  input  wire logic [ctcgd_pkg::COUNT_W-1:0]             divisor,
  output logic                                           done,
  output logic signed [ctcgd_pkg::SCORE_W-1:0]           quotient,
  output logic [ctcgd_pkg::COUNT_W-1:0]                  count
);

  localparam int unsigned TW = ctcgd_pkg::TOTAL_W;
  localparam int unsigned CW = ctcgd_pkg::COUNT_W;
  localparam int unsigned SW = ctcgd_pkg::SCORE_W;
  localparam int unsigned IW = $clog2(TW);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [IW-1:0] iter_r, iter_nxt;
  logic          neg_r, neg_nxt;
  logic [CW-1:0] dvs_r, dvs_nxt;
  logic [CW-1:0] rem_r, rem_nxt;
  logic [TW-1:0] quo_r, quo_nxt;
  logic [CW:0]   shifted;
  logic          ge;
  logic [CW:0]   diff;
  logic [TW-1:0] mag;
  logic [TW-1:0] signed_q;

  always_comb begin
    shifted = {rem_r, quo_r[TW-1]};
    ge = shifted >= {1'b0, dvs_r};
    diff = shifted - {1'b0, dvs_r};
    mag = dividend[TW-1] ? TW'(-dividend) : dividend;
    busy_nxt = busy_r;
    done_nxt = done_r;
    iter_nxt = iter_r;
    neg_nxt = neg_r;
    dvs_nxt = dvs_r;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
      iter_nxt = IW'(TW - 1);
      neg_nxt = dividend[TW-1];
      dvs_nxt = divisor;
      rem_nxt = '0;
      quo_nxt = mag;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[CW-1:0] : shifted[CW-1:0];
      quo_nxt = {quo_r[TW-2:0], ge};
      iter_nxt = iter_r - 1'b1;
      if (iter_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (ack) begin
      done_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    iter_r <= iter_nxt;
    neg_r <= neg_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  always_comb begin
    signed_q = neg_r ? TW'(-quo_r) : quo_r;
    quotient = (dvs_r == '0) ? '0 : signed_q[SW-1:0];
  end

  assign done = done_r;
  assign count = dvs_r;

endmodule
`default_nettype wire

>>> rtl/ctcgd_datapath.sv
// Datapath: running argmax, CTC merge, sequence totals and the result register.
`default_nettype none
module ctcgd_datapath #(
  parameter int unsigned MAX_CLASSES = 8192
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire ctcgd_pkg::in_item_t                   in_data,
  input  wire ctcgd_pkg::ctrl_cmd_t                  cmd,
  output ctcgd_pkg::dp_status_t                      status,
  ctcgd_out_if.source                                out_ch,
  input  wire logic                                  cfg_we,
  input  wire logic [ctcgd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [ctcgd_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int unsigned CNT_W = $clog2(MAX_CLASSES);
  localparam int unsigned SW = ctcgd_pkg::SCORE_W;
  localparam int unsigned KW = ctcgd_pkg::CLASS_W;
  localparam int unsigned CW = ctcgd_pkg::COUNT_W;
  localparam int unsigned TW = ctcgd_pkg::TOTAL_W;

  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic signed [SW-1:0] best_s_r, best_s_nxt;
  logic [CNT_W-1:0]     best_c_r, best_c_nxt;
  logic [KW-1:0]        prev_r, prev_nxt;
  logic signed [TW-1:0] total_r, total_nxt;
  logic [CW-1:0]        kept_r, kept_nxt;
  logic [KW-1:0]        blank_r, blank_nxt;
  logic signed [SW-1:0] thr_r, thr_nxt;
  ctcgd_pkg::out_item_t out_r, out_nxt;
  logic                 out_vld_r, out_vld_nxt;

  logic                 take;
  logic signed [SW-1:0] bs;
  logic [CNT_W-1:0]     bc;
  logic [31:0]          bc_wide;
  logic [KW-1:0]        w;
  logic                 emit;
  logic                 room;
  logic [CW-1:0]        kept_inc;
  logic signed [TW-1:0] total_inc;
  logic [CW-1:0]        kept_step;
  logic signed [TW-1:0] total_step;
  logic                 div_done;
  logic signed [SW-1:0] div_q;
  logic [CW-1:0]        div_cnt;

  always_comb begin
    take = (cnt_r == '0) || (in_data.score > best_s_r);
    bs = take ? in_data.score : best_s_r;
    bc = take ? cnt_r : best_c_r;
    bc_wide = 32'(bc);
    w = bc_wide[KW-1:0];
    emit = in_data.step_end && (w != prev_r) && (w < blank_r) && (bs >= thr_r);
    room = kept_r != ctcgd_pkg::COUNT_MAX;
    kept_inc = room ? kept_r + 1'b1 : kept_r;
    total_inc = room ? total_r + TW'(bs) : total_r;
    kept_step = emit ? kept_inc : kept_r;
    total_step = emit ? total_inc : total_r;
  end

  ctcgd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .ack      (cmd.load_sum),
    .dividend (total_step),
    .divisor  (kept_step),
    .done     (div_done),
    .quotient (div_q),
    .count    (div_cnt)
  );

  always_comb begin
    cnt_nxt = cnt_r;
    best_s_nxt = best_s_r;
    best_c_nxt = best_c_r;
    prev_nxt = prev_r;
    total_nxt = total_r;
    kept_nxt = kept_r;
    blank_nxt = blank_r;
    thr_nxt = thr_r;
    out_nxt = out_r;
    out_vld_nxt = out_vld_r && !out_ch.ready;

    if (cfg_we) begin
      case (cfg_index)
        ctcgd_pkg::CFG_BLANK_CLASS:    blank_nxt = cfg_data[KW-1:0];
        ctcgd_pkg::CFG_DROP_THRESHOLD: thr_nxt = cfg_data[SW-1:0];
        default: ;
      endcase
    end

    if (cmd.accept) begin
      if (in_data.step_end) begin
        cnt_nxt = '0;
        best_s_nxt = '0;
        best_c_nxt = '0;
        if (in_data.sequence_end) begin
          prev_nxt = blank_r;
          kept_nxt = '0;
          total_nxt = '0;
        end else begin
          prev_nxt = w;
          kept_nxt = kept_step;
          total_nxt = total_step;
        end
        if (emit) begin
          out_nxt.kind = ctcgd_pkg::KIND_CHAR;
          out_nxt.char_class = w;
          out_nxt.char_score = bs;
          out_nxt.mean_score = '0;
          out_nxt.kept_count = kept_inc;
          out_nxt.final_res = 1'b0;
          out_vld_nxt = 1'b1;
        end
      end else begin
        cnt_nxt = (cnt_r == CNT_W'(MAX_CLASSES - 1)) ? cnt_r : cnt_r + 1'b1;
        best_s_nxt = bs;
        best_c_nxt = bc;
      end
    end else if (cmd.load_sum) begin
      out_nxt.kind = ctcgd_pkg::KIND_SUMMARY;
      out_nxt.char_class = '0;
      out_nxt.char_score = '0;
      out_nxt.mean_score = div_q;
      out_nxt.kept_count = div_cnt;
      out_nxt.final_res = 1'b1;
      out_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      best_s_r <= '0;
      best_c_r <= '0;
      prev_r <= ctcgd_pkg::BLANK_RESET;
      total_r <= '0;
      kept_r <= '0;
      blank_r <= ctcgd_pkg::BLANK_RESET;
      thr_r <= ctcgd_pkg::THRESH_RESET;
      out_vld_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      best_s_r <= best_s_nxt;
      best_c_r <= best_c_nxt;
      prev_r <= prev_nxt;
      total_r <= total_nxt;
      kept_r <= kept_nxt;
      blank_r <= blank_nxt;
      thr_r <= thr_nxt;
      out_vld_r <= out_vld_nxt;
    end
    out_r <= out_nxt;
  end

  always_comb begin
    status.out_free = !out_vld_r || out_ch.ready;
    status.seq_close = in_data.step_end && in_data.sequence_end;
    status.div_done = div_done;
  end

  assign out_ch.valid = out_vld_r;
  assign out_ch.data = out_r;

endmodule
`default_nettype wire

>>> rtl/ctcgd_ctrl.sv
// Controller: input handshake, divider start and summary sequencing.
`default_nettype none
module ctcgd_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  input  wire ctcgd_pkg::dp_status_t  status,
  output logic                        in_ready,
  output ctcgd_pkg::ctrl_cmd_t        cmd
);

  typedef enum logic [1:0] {
    ST_RUN = 2'b01,
    ST_DIV = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    in_ready = 1'b0;
    cmd = '0;
    case (state_r)
      ST_RUN: begin
        in_ready = status.out_free;
        cmd.accept = in_valid && status.out_free;
        cmd.div_start = cmd.accept && status.seq_close;
        if (cmd.div_start) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (status.div_done && status.out_free) begin
          cmd.load_sum = 1'b1;
          state_nxt = ST_RUN;
        end
      end
      default: state_nxt = ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RUN;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/ctc_greedy_decoder_top.sv
// Top level of the CTC greedy best-path decoder.
//
//   channel  direction  handshake         payload
//   in_ch    sink       valid/ready       score, step_end, sequence_end
//   out_ch   source     valid/ready       kind, char_class, char_score, mean_score,
//                                         kept_count, final_res
//   cfg_*    sink       write enable      cfg_index, cfg_data
//
// One score item is taken per cycle while the result register is free or being emptied.
// An item that ends a sequence starts the serial divider, which produces one quotient bit
// per cycle; the summary is loaded once the divider is done and the result register is
// free, and no item is taken meanwhile. Reset is synchronous; there is no clearing pass.
// A stalled output holds the result register and input is held off until it frees.
`default_nettype none
module ctc_greedy_decoder_top #(
  parameter int unsigned MAX_CLASSES = 8192
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  ctcgd_in_if.sink                                 in_ch,
  ctcgd_out_if.source                              out_ch,
  input  wire logic                                cfg_we,
  input  wire logic [ctcgd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [ctcgd_pkg::CFG_DATA_W-1:0]    cfg_data
);

  ctcgd_pkg::ctrl_cmd_t cmd;
  ctcgd_pkg::dp_status_t status;
  logic in_ready;

  ctcgd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .status   (status),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  ctcgd_datapath #(
    .MAX_CLASSES (MAX_CLASSES)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_ch.data),
    .cmd       (cmd),
    .status    (status),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  assign in_ch.ready = in_ready;

endmodule
`default_nettype wire
